// ===== rtl/core/sor_poisson_grid_solver_unit_macros.svh =====
// assertion macros shared by the solver rtl
// no dependencies
`ifndef SOR_POISSON_GRID_SOLVER_UNIT_MACROS_SVH
`define SOR_POISSON_GRID_SOLVER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define SOR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define SOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/sor_pkg.sv =====
// package for the sor poisson grid solver: types, constants, arithmetic helpers
// no dependencies
package sor_pkg;
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = COL_W + ROW_W;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_RUN   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_WX     = 3'd2;
	localparam logic [2:0] REG_WY     = 3'd3;
	localparam logic [2:0] REG_RW     = 3'd4;
	localparam logic [2:0] REG_OMEGA  = 3'd5;
	localparam logic [2:0] REG_WALL   = 3'd6;

	typedef struct packed {
		logic [1:0]         action;
		logic [5:0]         col;
		logic [5:0]         row;
		logic signed [31:0] cell_value;
		logic signed [31:0] rhs_value;
		logic               solid_cell;
		logic [15:0]        iteration_limit;
		logic [31:0]        tolerance;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [15:0]        sweeps_done;
		logic [31:0]        residual;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_C, ST_RD_E, ST_RD_W, ST_RD_N, ST_RD_S, ST_MUL2, ST_MUL3,
		ST_ACC1, ST_ACC2, ST_GS, ST_OMEGA, ST_NEWV, ST_WB, ST_NEXT, ST_DONE
	} seq_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		if (v > 52'sd2147483647) return 32'sh7fffffff;
		if (v < -52'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

// ===== rtl/core/sor_cell_mem.sv =====
// potential, source and solid stores with registered reads
// depends on sor_pkg
module sor_cell_mem import sor_pkg::*; (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  logic signed [31:0]  wpot,
	input  logic signed [31:0]  wsrc,
	input  logic                wsolid,
	input  logic                wpot_only,
	input  logic [ADDR_W-1:0]   raddr,
	output logic signed [31:0]  rpot,
	output logic signed [31:0]  rsrc,
	output logic                rsolid
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	logic signed [31:0] pot_mem [DEPTH];
	logic signed [31:0] src_mem [DEPTH];
	logic               sol_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			pot_mem[waddr] <= wpot;
			if (!wpot_only) begin
				src_mem[waddr] <= wsrc;
				sol_mem[waddr] <= wsolid;
			end
		end
		rpot   <= pot_mem[raddr];
		rsrc   <= src_mem[raddr];
		rsolid <= sol_mem[raddr];
	end
endmodule

// ===== rtl/core/sor_poisson_grid_solver_unit.sv =====
// Write, read and ignored items are accepted one per cycle with busy low; each result
// strobe is registered through pend_q and then done_q after the accepting edge. A run item
// walks the interior cells one at a time through a single memory read port: five reads,
// five weight multiplies in a two-stage pipeline, an omega step and a write back; a solid
// cell goes on to the next cell once its centre read shows it solid. Busy stays high
// until the run's result strobe. A grid of width or height 2 or less, or a zero sweep
// limit, skips the sweeps and reports zero sweeps, with residual zero for such a grid and
// all ones otherwise. The receiver cannot stall and the result strobe is never held off.
// depends on sor_pkg, sor_cell_mem, sor_poisson_grid_solver_unit_macros.svh
`include "sor_poisson_grid_solver_unit_macros.svh"
module sor_poisson_grid_solver_unit import sor_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    in_item,
	output logic        done,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [6:0]  width_q, height_q;
	logic [31:0] wx_q, wy_q, rw_q;
	logic [17:0] omega_q;
	logic        wall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 7'd64; height_q <= 7'd64;
			wx_q <= 32'd16384; wy_q <= 32'd16384; rw_q <= 32'd16384;
			omega_q <= 18'd65536; wall_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q <= cfg_data[6:0];
				REG_HEIGHT: height_q <= cfg_data[6:0];
				REG_WX:     wx_q <= cfg_data;
				REG_WY:     wy_q <= cfg_data;
				REG_RW:     rw_q <= cfg_data;
				REG_OMEGA:  omega_q <= cfg_data[17:0];
				REG_WALL:   wall_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective grid, clamped to the store
	logic [6:0] nx, ny;
	assign nx = (width_q > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_q;
	assign ny = (height_q > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_q;

	seq_state_t state_q, state_d;
	logic [COL_W-1:0] ci_q;
	logic [ROW_W-1:0] rj_q;
	logic [15:0] limit_q, it_q;
	logic [31:0] tol_q, maxc_q, resid_q;
	logic signed [31:0] old_q, src_q, nb_q, gs_q, new_q;
	logic signed [35:0] om_q;
	logic signed [51:0] acc_q;
	logic [31:0] mulw_q;
	logic term_v_q, term_sub_q;
	logic signed [63:0] prod_s1;
	logic prod_v_s1, prod_sub_s1;
	logic pend_q, pend_rd_q;
	out_item_t res_q;
	logic done_q;
	logic accept;

	logic [ADDR_W-1:0] caddr, raddr, waddr, in_addr;
	logic signed [31:0] rpot, rsrc, wpot;
	logic rsolid;
	logic mem_we, wpot_only;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign caddr = {rj_q, ci_q};
	assign in_addr = {in_item.row[ROW_W-1:0], in_item.col[COL_W-1:0]};

	always_comb begin
		raddr = caddr;
		unique case (state_q)
			ST_IDLE: raddr = in_addr;
			ST_RD_E: raddr = caddr + ADDR_W'(1);
			ST_RD_W: raddr = caddr - ADDR_W'(1);
			ST_RD_N: raddr = caddr - ADDR_W'(MAX_WIDTH);
			ST_RD_S: raddr = caddr + ADDR_W'(MAX_WIDTH);
			default: raddr = caddr;
		endcase
	end

	assign mem_we = (accept && in_item.action == ACT_WRITE) || state_q == ST_WB;
	assign wpot_only = (state_q == ST_WB);
	assign waddr = (state_q == ST_WB) ? caddr : in_addr;
	assign wpot = (state_q == ST_WB) ? new_q : in_item.cell_value;

	sor_cell_mem u_mem (
		.clk(clk), .we(mem_we), .waddr(waddr), .wpot(wpot), .wsrc(in_item.rhs_value),
		.wsolid(in_item.solid_cell), .wpot_only(wpot_only), .raddr(raddr),
		.rpot(rpot), .rsrc(rsrc), .rsolid(rsolid)
	);

	// neighbor value arriving from memory (read issued last cycle)
	logic signed [31:0] nb_val;
	assign nb_val = (wall_q && rsolid) ? old_q : rpot;

	// weight times term, shifted right by 16 bits (floored)
	logic signed [63:0] prod_d;
	logic signed [47:0] fl_s1;
	assign prod_d = $signed({1'b0, mulw_q}) * nb_q;
	assign fl_s1 = prod_s1[63:16];

	logic is_last_col, is_last_row, stop;
	assign is_last_col = ({1'b0, ci_q} + 7'd2 >= nx);
	assign is_last_row = ({1'b0, rj_q} + 7'd2 >= ny);
	assign stop = ({1'b0, it_q} + 17'd1 >= {1'b0, limit_q})
		|| (maxc_q < tol_q && it_q != 16'd0);

	// omega step and change
	logic signed [32:0] diff;
	logic signed [51:0] om_prod;
	logic signed [32:0] ch;
	logic [31:0] ch_abs;
	assign diff = 33'(gs_q) - 33'(old_q);
	assign om_prod = $signed({1'b0, omega_q}) * diff;
	assign ch = 33'(new_q) - 33'(old_q);
	assign ch_abs = ch[32] ? 32'(-ch) : ch[31:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start && in_item.action == ACT_RUN) begin
				if (nx <= 7'd2 || ny <= 7'd2 || in_item.iteration_limit == 16'd0)
					state_d = ST_DONE;
				else
					state_d = ST_RD_C;
			end
			ST_RD_C: state_d = ST_RD_E;
			ST_RD_E: state_d = rsolid ? ST_NEXT : ST_RD_W;
			ST_RD_W: state_d = ST_RD_N;
			ST_RD_N: state_d = ST_RD_S;
			ST_RD_S: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_ACC1;
			ST_ACC1: state_d = ST_ACC2;
			ST_ACC2: state_d = ST_GS;
			ST_GS: state_d = ST_OMEGA;
			ST_OMEGA: state_d = ST_NEWV;
			ST_NEWV: state_d = ST_WB;
			ST_WB: state_d = ST_NEXT;
			ST_NEXT: state_d = (is_last_col && is_last_row && stop) ? ST_DONE : ST_RD_C;
			ST_DONE: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			pend_q <= 1'b0;
			pend_rd_q <= 1'b0;
			term_v_q <= 1'b0;
			prod_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q <= accept && (in_item.action != ACT_RUN);
			pend_rd_q <= accept && (in_item.action == ACT_READ);
			done_q <= pend_q || (state_q == ST_DONE);
			// E, W, N, S and rhs terms enter the multiply pipeline
			term_v_q <= (state_q == ST_RD_W) || (state_q == ST_RD_N) || (state_q == ST_RD_S)
				|| (state_q == ST_MUL2) || (state_q == ST_MUL3);
			prod_v_s1 <= term_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q)
			res_q <= pend_rd_q ? '{read_value: rpot, sweeps_done: 16'd0, residual: 32'd0}
				: '0;
		else if (state_q == ST_DONE)
			res_q <= '{read_value: 32'sd0, sweeps_done: it_q, residual: resid_q};

		if (accept && in_item.action == ACT_RUN) begin
			limit_q <= in_item.iteration_limit;
			tol_q <= in_item.tolerance;
			ci_q <= COL_W'(1);
			rj_q <= ROW_W'(1);
			it_q <= 16'd0;
			maxc_q <= 32'd0;
			resid_q <= (nx <= 7'd2 || ny <= 7'd2) ? 32'd0 : 32'hffffffff;
		end

		if (state_q == ST_RD_E) begin
			old_q <= rpot;
			src_q <= rsrc;
		end

		if (state_q == ST_MUL3) begin
			nb_q <= src_q;
			mulw_q <= rw_q;
		end else begin
			nb_q <= nb_val;
			mulw_q <= (state_q == ST_RD_W || state_q == ST_RD_N) ? wx_q : wy_q;
		end
		term_sub_q <= (state_q == ST_MUL3);
		prod_s1 <= prod_d;
		prod_sub_s1 <= term_sub_q;

		// rhs term is subtracted, neighbors added
		if (state_q == ST_RD_E)
			acc_q <= '0;
		else if (prod_v_s1)
			acc_q <= prod_sub_s1 ? acc_q - 52'(fl_s1) : acc_q + 52'(fl_s1);

		if (state_q == ST_GS) gs_q <= sat32(acc_q);
		if (state_q == ST_OMEGA) om_q <= om_prod[51:16];
		if (state_q == ST_NEWV) new_q <= sat32(52'(old_q) + 52'(om_q));
		if (state_q == ST_WB && ch_abs > maxc_q) maxc_q <= ch_abs;

		if (state_q == ST_NEXT) begin
			if (is_last_col) begin
				ci_q <= COL_W'(1);
				if (is_last_row) begin
					rj_q <= ROW_W'(1);
					it_q <= it_q + 16'd1;
					resid_q <= maxc_q;
					maxc_q <= 32'd0;
				end else rj_q <= rj_q + ROW_W'(1);
			end else ci_q <= ci_q + COL_W'(1);
		end
	end

	assign done = done_q;
	assign out_item = res_q;

	`SOR_ASSERT_IMP(a_no_write_busy, clk, arst_n, state_q == ST_WB, busy)
	`SOR_ASSERT_NEXT(a_item_strobe, clk, arst_n, pend_q, done_q)
	`SOR_ASSERT_NEXT(a_done_idle, clk, arst_n, state_q == ST_DONE, done_q && !busy)
	`SOR_ASSERT_IMP(a_pend_idle, clk, arst_n, pend_q, state_q != ST_DONE)
endmodule

// ===== sim/sor_poisson_grid_solver_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench for sor_poisson_grid_solver_unit: cell writes, reads and solver runs
// are checked against a fixed-point relaxation model kept in a scoreboard class
// depends on sor_pkg and the solver rtl
module sor_poisson_grid_solver_unit_tb;
	import sor_pkg::*;

	localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
	localparam int CYCLE_LIMIT = 10000000;
	localparam int ITEM_TARGET = 1100;

	class sor_scoreboard;
		int          potential[CELL_COUNT];
		int          source[CELL_COUNT];
		bit          solid[CELL_COUNT];
		int unsigned width_reg, height_reg, wx, wy, rw, omega;
		bit          wall;
		out_item_t   pending_results[$];
		int          mismatches;

		function new();
			width_reg = 64;
			height_reg = 64;
			wx = 16384;
			wy = 16384;
			rw = 16384;
			omega = 65536;
			wall = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_WIDTH:  width_reg = data[6:0];
				REG_HEIGHT: height_reg = data[6:0];
				REG_WX:     wx = data;
				REG_WY:     wy = data;
				REG_RW:     rw = data;
				REG_OMEGA:  omega = data[17:0];
				REG_WALL:   wall = data[0];
				default: ;
			endcase
		endfunction

		function longint weigh(int unsigned w, int x);
			return (longint'(w) * longint'(x)) >>> 16;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function int neighbor(int idx, int own);
			if (wall && solid[idx]) return own;
			return potential[idx];
		endfunction

		// in-place sweeps, returns sweep count and last residual
		function void relax_grid(int unsigned limit, int unsigned tol,
				output int unsigned sweeps, output int unsigned resid);
			int unsigned nx, ny, maxc;
			int c, old;
			longint gs, nw, ch;
			nx = (width_reg < MAX_WIDTH) ? width_reg : MAX_WIDTH;
			ny = (height_reg < MAX_HEIGHT) ? height_reg : MAX_HEIGHT;
			sweeps = 0;
			resid = 0;
			if (nx <= 2 || ny <= 2) return;
			resid = 32'hffffffff;
			for (int unsigned it = 0; it < limit; it++) begin
				maxc = 0;
				for (int j = 1; j + 1 < ny; j++) begin
					for (int i = 1; i + 1 < nx; i++) begin
						c = j * MAX_WIDTH + i;
						if (solid[c]) continue;
						old = potential[c];
						gs = weigh(wx, neighbor(c + 1, old)) + weigh(wx, neighbor(c - 1, old))
							+ weigh(wy, neighbor(c + MAX_WIDTH, old))
							+ weigh(wy, neighbor(c - MAX_WIDTH, old))
							- weigh(rw, source[c]);
						gs = clamp32(gs);
						nw = clamp32(longint'(old) + ((longint'(omega) * (gs - longint'(old))) >>> 16));
						potential[c] = int'(nw);
						ch = nw - longint'(old);
						if (ch < 0) ch = -ch;
						if (ch > 64'sd4294967295) ch = 64'sd4294967295;
						if (ch > longint'(maxc)) maxc = 32'(ch);
					end
				end
				resid = maxc;
				sweeps = it + 1;
				if (resid < tol && it > 0) break;
			end
		endfunction

		function void accept_item(in_item_t it);
			out_item_t r;
			int addr;
			int unsigned sw, res;
			r = '0;
			addr = it.row * MAX_WIDTH + it.col;
			case (it.action)
				ACT_WRITE: begin
					potential[addr] = it.cell_value;
					source[addr] = it.rhs_value;
					solid[addr] = it.solid_cell;
				end
				ACT_READ: r.read_value = potential[addr];
				ACT_RUN: begin
					relax_grid(it.iteration_limit, it.tolerance, sw, res);
					r.sweeps_done = sw[15:0];
					r.residual = res;
				end
				default: ;
			endcase
			pending_results.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				report(got, '0, "unexpected result");
				return;
			end
			want = pending_results.pop_front();
			if (got.read_value !== want.read_value || got.sweeps_done !== want.sweeps_done
					|| got.residual !== want.residual)
				report(got, want, "field mismatch");
		endfunction

		function void report(out_item_t got, out_item_t want, string what);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t %s: read %h/%h sweeps %0d/%0d residual %h/%h (got/exp)",
					$realtime, what, got.read_value, want.read_value, got.sweeps_done,
					want.sweeps_done, got.residual, want.residual);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    in_item;
	logic        done;
	out_item_t   out_item;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	sor_poisson_grid_solver_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .out_item(out_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sor_scoreboard sb = new();
	bit            loaded[CELL_COUNT];
	int            items_sent = 0;
	int            burst_left = 0;
	int unsigned   cycles = 0;
	int unsigned   cur_w = 64, cur_h = 64;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sor_poisson_grid_solver_unit_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.accept_item(in_item);
			if (done) sb.check_result(out_item);
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: case ($urandom_range(0, 3))
				0: return 32'h7fffffff;
				1: return 32'h80000000;
				2: return 32'h0;
				default: return 32'hffffffff;
			endcase
			default: return (32'($urandom_range(0, 16)) - 32'd8) <<< 16 | 32'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		return it;
	endfunction

	function automatic in_item_t write_item(int c, int r);
		in_item_t it;
		it = noise_item();
		it.action = ACT_WRITE;
		it.col = 6'(c);
		it.row = 6'(r);
		it.cell_value = pick_value();
		it.rhs_value = pick_value();
		it.solid_cell = ($urandom_range(0, 5) == 0);
		return it;
	endfunction

	function automatic in_item_t read_item(int c, int r);
		in_item_t it;
		it = noise_item();
		it.action = ACT_READ;
		it.col = 6'(c);
		it.row = 6'(r);
		return it;
	endfunction

	function automatic in_item_t run_item(int unsigned limit, logic [31:0] tol);
		in_item_t it;
		it = noise_item();
		it.action = ACT_RUN;
		it.iteration_limit = 16'(limit);
		it.tolerance = tol;
		return it;
	endfunction

	task automatic send(in_item_t it);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		start <= 1'b1;
		in_item <= it;
		if (it.action == ACT_WRITE) loaded[it.row * MAX_WIDTH + it.col] = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() > 0 || busy);
		repeat (16) @(posedge clk);
	endtask

	task automatic configure(int unsigned w, int unsigned h, logic [31:0] wxv, logic [31:0] wyv,
			logic [31:0] rwv, logic [31:0] om, bit wl);
		logic [31:0] vals[7];
		vals = '{w, h, wxv, wyv, rwv, om, 32'(wl)};
		for (int k = 0; k < 7; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= k[2:0];
			cfg_data <= vals[k];
			sb.set_reg(k[2:0], vals[k]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_w = (w[6:0] < MAX_WIDTH) ? w[6:0] : MAX_WIDTH;
		cur_h = (h[6:0] < MAX_HEIGHT) ? h[6:0] : MAX_HEIGHT;
	endtask

	// every cell a run may touch must hold a written value
	task automatic fill_region();
		for (int r = 0; r < cur_h; r++)
			for (int c = 0; c < cur_w; c++)
				if (!loaded[r * MAX_WIDTH + c]) send(write_item(c, r));
	endtask

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hffffffff;
			2: return $urandom;
			default: return $urandom_range(32'h2000, 32'h6000);
		endcase
	endfunction

	task automatic random_phase();
		int unsigned w, h, n, limit;
		logic [31:0] om, tol;
		in_item_t it;
		case ($urandom_range(0, 11))
			0: begin w = $urandom_range(1, 2); h = $urandom_range(1, 127); end
			1: begin w = $urandom_range(3, 8); h = $urandom_range(1, 2); end
			2: begin w = ($urandom_range(0, 1)) ? 64 : $urandom_range(65, 127); h = 3; end
			3: begin w = 3; h = ($urandom_range(0, 1)) ? 64 : $urandom_range(65, 127); end
			default: begin w = $urandom_range(3, 7); h = $urandom_range(3, 7); end
		endcase
		case ($urandom_range(0, 4))
			0: om = 0;
			1: om = 131072;
			2: om = $urandom_range(0, 131072);
			default: om = $urandom_range(65536, 122000);
		endcase
		configure(w, h, pick_weight(), pick_weight(), pick_weight(), om, $urandom_range(0, 1));
		fill_region();
		n = $urandom_range(20, 60);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: send(write_item($urandom_range(0, cur_w - 1),
					$urandom_range(0, cur_h - 1)));
				7: send(write_item($urandom_range(0, 63), $urandom_range(0, 63)));
				8, 9, 10, 11, 12, 13: send(read_item($urandom_range(0, cur_w - 1),
					$urandom_range(0, cur_h - 1)));
				14: begin
					it = noise_item();
					it.action = ACT_NONE;
					send(it);
				end
				default: begin
					limit = (cur_w * cur_h > 64) ? $urandom_range(0, 4) : $urandom_range(0, 16);
					case ($urandom_range(0, 3))
						0: tol = 0;
						1: tol = $urandom;
						default: tol = $urandom_range(0, 32'h20000);
					endcase
					send(run_item(limit, tol));
				end
			endcase
		end
		drain();
	endtask

	initial begin
		in_item_t it;
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners of the store, two with extreme contents, then three of them read back and one ignored item
		it = write_item(0, 0);
		it.cell_value = 32'h7fffffff;
		it.rhs_value = 32'h80000000;
		send(it);
		it = write_item(63, 63);
		it.cell_value = 32'h80000000;
		it.rhs_value = 32'h7fffffff;
		it.solid_cell = 1'b1;
		send(it);
		send(write_item(63, 0));
		send(write_item(0, 63));
		send(read_item(0, 0));
		send(read_item(63, 63));
		send(read_item(63, 0));
		it = noise_item();
		it.action = ACT_NONE;
		send(it);
		drain();

		// smallest grid with a real interior cell, then two grids too narrow or too short to have one
		configure(3, 3, 16384, 16384, 16384, 65536, 0);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				it = write_item(c, r);
				it.cell_value = 32'($urandom_range(0, 4)) << 16;
				it.rhs_value = 32'h10000;
				it.solid_cell = 1'b0;
				send(it);
			end
		send(run_item(0, 0));
		send(run_item(1, 0));
		send(run_item(65535, 32'hffffffff));
		send(run_item(3, 0));
		send(read_item(1, 1));
		drain();
		configure(2, 64, 16384, 16384, 16384, 65536, 1);
		send(run_item(5, 0));
		drain();
		configure(64, 1, 16384, 16384, 16384, 65536, 1);
		send(run_item(5, 0));
		drain();

		while (items_sent < ITEM_TARGET) random_phase();
		drain();

		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("sor_poisson_grid_solver_unit_tb: PASS");
		else
			$display("sor_poisson_grid_solver_unit_tb: FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sor_pkg.sv
rtl/core/sor_cell_mem.sv
rtl/core/sor_poisson_grid_solver_unit.sv
sim/sor_poisson_grid_solver_unit_tb.sv
